// ===== src/efd_pkg.sv =====
// efd_pkg: shared types and constants for the escaped frame decoder
// no dependencies; imported by efd_deframer and the top level
`default_nettype none

package efd_pkg;

    // result kinds
    localparam logic [2:0] EV_BODY   = 3'd0;
    localparam logic [2:0] EV_OK     = 3'd1;
    localparam logic [2:0] EV_CRC    = 3'd2;
    localparam logic [2:0] EV_TRUNC  = 3'd3;
    localparam logic [2:0] EV_BADLEN = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_MAGIC   = 3'd0;
    localparam logic [2:0] REG_ESCAPE  = 3'd1;
    localparam logic [2:0] REG_XORMASK = 3'd2;
    localparam logic [2:0] REG_POLY    = 3'd3;
    localparam logic [2:0] REG_START   = 3'd4;
    localparam logic [2:0] REG_MAXLEN  = 3'd5;

    localparam logic [15:0] CRC_MSB     = 16'h8000;
    localparam logic [15:0] MIN_BODY    = 16'd2;
    localparam int          BYTE_BITS   = 8;

    // configuration seen by the deframer
    typedef struct packed {
        logic [7:0]  magic_byte;
        logic [7:0]  escape_byte;
        logic [7:0]  escape_xor_mask;
        logic [15:0] crc_polynomial;
        logic [15:0] crc_start_value;
        logic [15:0] max_body_length;
    } efd_cfg_t;

    // msb-first crc16 update over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [7:0]  b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < BYTE_BITS; k++) begin
            if ((c & CRC_MSB) != 16'h0000)
            begin
                c = {c[14:0], 1'b0} ^ poly;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/efd_deframer.sv =====
// efd_deframer: per-byte frame state machine, crc and counters, with result register
// depends on efd_pkg (config struct, result kinds, crc_byte)
`default_nettype none

module efd_deframer
    import efd_pkg::*;
#(
    parameter int COUNTER_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire efd_cfg_t    cfg,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       event_kind,
    output logic [7:0]       data_byte,
    output logic [15:0]      byte_index,
    output logic [31:0]      good_frames,
    output logic [31:0]      crc_error_frames,
    output logic [31:0]      truncated_frames,
    output logic [31:0]      skipped_bytes
);

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_BODY   = 3'd3,
        PH_CRC_HI = 3'd4,
        PH_CRC_LO = 3'd5
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic                      esc_reg, esc_next;
    logic [15:0]               flen_reg, flen_next;
    logic [15:0]               bcount_reg, bcount_next;
    logic [7:0]                crc_hi_reg, crc_hi_next;
    logic [15:0]               crc_reg, crc_next;
    logic [COUNTER_BITS-1:0]   ok_reg, ok_next;
    logic [COUNTER_BITS-1:0]   cerr_reg, cerr_next;
    logic [COUNTER_BITS-1:0]   trunc_reg, trunc_next;
    logic [COUNTER_BITS-1:0]   skip_reg, skip_next;

    logic                      emit;
    logic [2:0]                kind;
    logic [7:0]                dbyte;
    logic [15:0]               idx;

    logic                      valid_reg;
    logic [2:0]                kind_reg;
    logic [7:0]                data_reg;
    logic [15:0]               idx_reg;

    logic                      accept;
    logic [7:0]                b;
    logic [15:0]               len;
    logic [15:0]               bcount_inc;

    // result register frees as soon as its transaction is taken
    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign b          = esc_reg ? (rx_byte ^ cfg.escape_xor_mask) : rx_byte;
    assign len        = {flen_reg[15:8], b};
    assign bcount_inc = bcount_reg + 16'd1;

    // next state for one received byte
    always_comb
    begin
        phase_next  = phase_reg;
        esc_next    = esc_reg;
        flen_next   = flen_reg;
        bcount_next = bcount_reg;
        crc_hi_next = crc_hi_reg;
        crc_next    = crc_reg;
        ok_next     = ok_reg;
        cerr_next   = cerr_reg;
        trunc_next  = trunc_reg;
        skip_next   = skip_reg;
        emit        = 1'b0;
        kind        = EV_BODY;
        dbyte       = 8'h00;
        idx         = 16'h0000;

        if (rx_byte == cfg.magic_byte)
        begin
            // magic always opens a new frame
            if (phase_reg != PH_HUNT)
            begin
                trunc_next = trunc_reg + COUNTER_BITS'(1);
                skip_next  = skip_reg + COUNTER_BITS'(bcount_reg);
                emit       = 1'b1;
                kind       = EV_TRUNC;
                idx        = bcount_reg;
            end
            phase_next  = PH_LEN_HI;
            esc_next    = 1'b0;
            flen_next   = 16'h0000;
            bcount_next = 16'h0000;
            crc_next    = crc_byte(cfg.crc_start_value, rx_byte, cfg.crc_polynomial);
        end
        else if (phase_reg == PH_HUNT)
        begin
            skip_next = skip_reg + COUNTER_BITS'(1);
        end
        else if (!esc_reg && rx_byte == cfg.escape_byte)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            esc_next = 1'b0;
            case (phase_reg)
                PH_LEN_HI:
                begin
                    flen_next  = {b, 8'h00};
                    crc_next   = crc_byte(crc_reg, b, cfg.crc_polynomial);
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    crc_next    = crc_byte(crc_reg, b, cfg.crc_polynomial);
                    bcount_next = 16'h0000;
                    if (len < MIN_BODY || len > cfg.max_body_length)
                    begin
                        trunc_next = trunc_reg + COUNTER_BITS'(1);
                        phase_next = PH_HUNT;
                        flen_next  = 16'h0000;
                        emit       = 1'b1;
                        kind       = EV_BADLEN;
                        idx        = len;
                    end
                    else
                    begin
                        flen_next  = len;
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    crc_next    = crc_byte(crc_reg, b, cfg.crc_polynomial);
                    bcount_next = bcount_inc;
                    if (bcount_inc >= flen_reg)
                    begin
                        phase_next = PH_CRC_HI;
                    end
                    emit  = 1'b1;
                    kind  = EV_BODY;
                    dbyte = b;
                    idx   = bcount_reg;
                end
                PH_CRC_HI:
                begin
                    crc_hi_next = b;
                    phase_next  = PH_CRC_LO;
                end
                PH_CRC_LO:
                begin
                    if ({crc_hi_reg, b} == crc_reg)
                    begin
                        ok_next = ok_reg + COUNTER_BITS'(1);
                        kind    = EV_OK;
                    end
                    else
                    begin
                        cerr_next = cerr_reg + COUNTER_BITS'(1);
                        kind      = EV_CRC;
                    end
                    emit        = 1'b1;
                    idx         = flen_reg;
                    phase_next  = PH_HUNT;
                    flen_next   = 16'h0000;
                    bcount_next = 16'h0000;
                end
                default:
                begin
                    phase_next  = PH_HUNT;
                    flen_next   = 16'h0000;
                    bcount_next = 16'h0000;
                end
            endcase
        end
    end

    // frame state, counters and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            esc_reg          <= 1'b0;
            flen_reg         <= 16'h0000;
            bcount_reg       <= 16'h0000;
            crc_hi_reg       <= 8'h00;
            crc_reg          <= 16'hD77F;
            ok_reg           <= '0;
            cerr_reg         <= '0;
            trunc_reg        <= '0;
            skip_reg         <= '0;
            valid_reg        <= 1'b0;
            kind_reg         <= EV_BODY;
            data_reg         <= 8'h00;
            idx_reg          <= 16'h0000;
            good_frames      <= 32'h0;
            crc_error_frames <= 32'h0;
            truncated_frames <= 32'h0;
            skipped_bytes    <= 32'h0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg  <= phase_next;
                esc_reg    <= esc_next;
                flen_reg   <= flen_next;
                bcount_reg <= bcount_next;
                crc_hi_reg <= crc_hi_next;
                crc_reg    <= crc_next;
                ok_reg     <= ok_next;
                cerr_reg   <= cerr_next;
                trunc_reg  <= trunc_next;
                skip_reg   <= skip_next;
            end
            // result valid
            if (in_ready)
            begin
                valid_reg <= accept && emit;
            end
            // result payload, counters are sampled after this byte's update
            if (accept && emit)
            begin
                kind_reg         <= kind;
                data_reg         <= dbyte;
                idx_reg          <= idx;
                good_frames      <= 32'(ok_next);
                crc_error_frames <= 32'(cerr_next);
                truncated_frames <= 32'(trunc_next);
                skipped_bytes    <= 32'(skip_next);
            end
        end
    end

    assign out_valid  = valid_reg;
    assign event_kind = kind_reg;
    assign data_byte  = data_reg;
    assign byte_index = idx_reg;

endmodule

`default_nettype wire

// ===== src/escaped_frame_decoder_crc16_top.sv =====
// escaped_frame_decoder_crc16_top: apb configuration registers around the deframer
// depends on efd_pkg and efd_deframer
//
//  channel   handshake                  payload
//  -------   -------------------------  --------------------------------------------
//  input     in_valid / in_ready        rx_byte
//  output    out_valid / out_ready      event_kind, data_byte, byte_index, counters
//  config    psel, penable, pwrite, ..  paddr, pwdata, prdata (32 bit, 4*i)
//
// one byte per cycle while no result stalls: each byte steps the frame state and crc in the cycle it is
// accepted, and any result appears in the result register the next cycle.
// the crc byte update (eight shift-xor steps) sets the cycle path.
// reset clears the frame state and counters and loads the default registers.
// a stalled result holds only the input side; in_ready stays high while out_ready is.
`default_nettype none

module escaped_frame_decoder_crc16_top
    import efd_pkg::*;
#(
    parameter int COUNTER_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       event_kind,
    output logic [7:0]       data_byte,
    output logic [15:0]      byte_index,
    output logic [31:0]      good_frames,
    output logic [31:0]      crc_error_frames,
    output logic [31:0]      truncated_frames,
    output logic [31:0]      skipped_bytes
);

    efd_cfg_t    cfg_reg;
    logic [2:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_byte      <= 8'd253;
            cfg_reg.escape_byte     <= 8'd252;
            cfg_reg.escape_xor_mask <= 8'd128;
            cfg_reg.crc_polynomial  <= 16'h8005;
            cfg_reg.crc_start_value <= 16'hD77F;
            cfg_reg.max_body_length <= 16'd514;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MAGIC:   cfg_reg.magic_byte      <= pwdata[7:0];
                REG_ESCAPE:  cfg_reg.escape_byte     <= pwdata[7:0];
                REG_XORMASK: cfg_reg.escape_xor_mask <= pwdata[7:0];
                REG_POLY:    cfg_reg.crc_polynomial  <= pwdata[15:0];
                REG_START:   cfg_reg.crc_start_value <= pwdata[15:0];
                REG_MAXLEN:  cfg_reg.max_body_length <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx)
            REG_MAGIC:   prdata = {24'h0, cfg_reg.magic_byte};
            REG_ESCAPE:  prdata = {24'h0, cfg_reg.escape_byte};
            REG_XORMASK: prdata = {24'h0, cfg_reg.escape_xor_mask};
            REG_POLY:    prdata = {16'h0, cfg_reg.crc_polynomial};
            REG_START:   prdata = {16'h0, cfg_reg.crc_start_value};
            REG_MAXLEN:  prdata = {16'h0, cfg_reg.max_body_length};
            default:     prdata = 32'h0;
        endcase
    end

    // byte-level deframer
    efd_deframer #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_deframer (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .event_kind       (event_kind),
        .data_byte        (data_byte),
        .byte_index       (byte_index),
        .good_frames      (good_frames),
        .crc_error_frames (crc_error_frames),
        .truncated_frames (truncated_frames),
        .skipped_bytes    (skipped_bytes)
    );

endmodule

`default_nettype wire

// ===== sim/tb_escaped_frame_decoder_crc16_top.sv =====
`timescale 1ns / 1ps
// tb_escaped_frame_decoder_crc16_top: self-checking testbench for the escaped frame decoder
// depends on efd_pkg and escaped_frame_decoder_crc16_top; line bytes in, checked events out

module tb_escaped_frame_decoder_crc16_top;
    import efd_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 12;
    localparam int STALL_LIMIT  = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TOTAL_BYTES  = 1850;
    localparam int MAX_REPORTS  = 10;

    // register values after reset
    localparam logic [7:0]  DEF_MAGIC   = 8'd253;
    localparam logic [7:0]  DEF_ESCAPE  = 8'd252;
    localparam logic [7:0]  DEF_XORMASK = 8'd128;
    localparam logic [15:0] DEF_POLY    = 16'h8005;
    localparam logic [15:0] DEF_START   = 16'hD77F;
    localparam logic [15:0] DEF_MAXLEN  = 16'd514;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY,
        PH_CRC_HI,
        PH_CRC_LO
    } deframe_phase_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [15:0] index;
        logic [31:0] good;
        logic [31:0] crc_err;
        logic [31:0] trunc;
        logic [31:0] skipped;
    } frame_event_t;

    // dut signals
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [4:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  event_kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [31:0] good_frames;
    logic [31:0] crc_error_frames;
    logic [31:0] truncated_frames;
    logic [31:0] skipped_bytes;

    // register mirror
    logic [7:0]  cfg_magic;
    logic [7:0]  cfg_escape;
    logic [7:0]  cfg_mask;
    logic [15:0] cfg_poly;
    logic [15:0] cfg_start;
    logic [15:0] cfg_max_len;

    // deframer state as predicted
    deframe_phase_t m_phase;
    logic           m_esc_pending;
    logic [15:0]    m_frame_len;
    logic [15:0]    m_body_count;
    logic [7:0]     m_crc_high;
    logic [15:0]    m_crc;
    logic [31:0]    m_good;
    logic [31:0]    m_crc_err;
    logic [31:0]    m_trunc;
    logic [31:0]    m_skipped;

    frame_event_t expected_events[$];

    int error_count  = 0;
    int frame_bytes  = 0;
    int quiet_cycles = 0;
    int ready_hold   = 0;
    bit idle_on      = 1'b1;

    escaped_frame_decoder_crc16_top u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .event_kind       (event_kind),
        .data_byte        (data_byte),
        .byte_index       (byte_index),
        .good_frames      (good_frames),
        .crc_error_frames (crc_error_frames),
        .truncated_frames (truncated_frames),
        .skipped_bytes    (skipped_bytes)
    );

    always #(CLK_HALF) clk = ~clk;

    // msb-first crc16, one data bit folded in per shift
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] d,
                                                 input logic [15:0] poly);
        logic [15:0] c;
        logic        fb;
        int          i;
        c = crc;
        for (i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ d[i];
            c = {c[14:0], 1'b0};
            if (fb)
            begin
                c = c ^ poly;
            end
        end
        return c;
    endfunction

    // stall length: mostly short, now and then long
    function automatic int stall_length();
        if ($urandom_range(0, 99) < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_gap();
        if (!idle_on || $urandom_range(0, 99) < 60)
        begin
            return 0;
        end
        return stall_length();
    endfunction

    // body bytes lean on the magic and escape values so stuffing gets exercised
    function automatic logic [7:0] pick_body_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            return cfg_magic;
        end
        if (r < 24)
        begin
            return cfg_escape;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // mostly short bodies, some at the limit, a few long
    function automatic int pick_body_len();
        int hi;
        int r;
        if (cfg_max_len < MIN_BODY)
        begin
            hi = 4;
        end
        else if (cfg_max_len > 16'd520)
        begin
            hi = 520;
        end
        else
        begin
            hi = int'(cfg_max_len);
        end
        r = $urandom_range(0, 99);
        if (r < 82)
        begin
            return $urandom_range(2, (hi < 8) ? hi : 8);
        end
        if (r < 86)
        begin
            return hi;
        end
        if (r < 99)
        begin
            return $urandom_range(2, (hi < 40) ? hi : 40);
        end
        return $urandom_range(2, hi);
    endfunction

    task automatic model_reset();
        cfg_magic     = DEF_MAGIC;
        cfg_escape    = DEF_ESCAPE;
        cfg_mask      = DEF_XORMASK;
        cfg_poly      = DEF_POLY;
        cfg_start     = DEF_START;
        cfg_max_len   = DEF_MAXLEN;
        m_phase       = PH_HUNT;
        m_esc_pending = 1'b0;
        m_frame_len   = '0;
        m_body_count  = '0;
        m_crc_high    = '0;
        m_crc         = DEF_START;
        m_good        = '0;
        m_crc_err     = '0;
        m_trunc       = '0;
        m_skipped     = '0;
    endtask

    task automatic back_to_hunt();
        m_phase       = PH_HUNT;
        m_esc_pending = 1'b0;
        m_frame_len   = '0;
        m_body_count  = '0;
    endtask

    task automatic queue_event(input logic [2:0] kind, input logic [7:0] data,
                               input logic [15:0] index);
        frame_event_t ev;
        ev.kind    = kind;
        ev.data    = data;
        ev.index   = index;
        ev.good    = m_good;
        ev.crc_err = m_crc_err;
        ev.trunc   = m_trunc;
        ev.skipped = m_skipped;
        expected_events.push_back(ev);
    endtask

    // advance the predicted deframer by one accepted line byte
    task automatic decode_byte(input logic [7:0] raw);
        logic [7:0]  b;
        logic [15:0] len;
        if (raw == cfg_magic)
        begin
            // magic always restarts; an open frame is cut
            if (m_phase != PH_HUNT)
            begin
                m_trunc   = m_trunc + 32'd1;
                m_skipped = m_skipped + 32'(m_body_count);
                queue_event(EV_TRUNC, 8'h00, m_body_count);
            end
            back_to_hunt();
            m_phase = PH_LEN_HI;
            m_crc   = crc16_update(cfg_start, raw, cfg_poly);
        end
        else if (m_phase == PH_HUNT)
        begin
            m_skipped = m_skipped + 32'd1;
        end
        else if (!m_esc_pending && raw == cfg_escape)
        begin
            m_esc_pending = 1'b1;
        end
        else
        begin
            b = m_esc_pending ? (raw ^ cfg_mask) : raw;
            m_esc_pending = 1'b0;
            case (m_phase)
                PH_LEN_HI:
                begin
                    m_frame_len = {b, 8'h00};
                    m_crc       = crc16_update(m_crc, b, cfg_poly);
                    m_phase     = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len          = m_frame_len | {8'h00, b};
                    m_crc        = crc16_update(m_crc, b, cfg_poly);
                    m_body_count = '0;
                    if (len < MIN_BODY || len > cfg_max_len)
                    begin
                        m_trunc = m_trunc + 32'd1;
                        back_to_hunt();
                        queue_event(EV_BADLEN, 8'h00, len);
                    end
                    else
                    begin
                        m_frame_len = len;
                        m_phase     = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    queue_event(EV_BODY, b, m_body_count);
                    m_crc        = crc16_update(m_crc, b, cfg_poly);
                    m_body_count = m_body_count + 16'd1;
                    if (m_body_count >= m_frame_len)
                    begin
                        m_phase = PH_CRC_HI;
                    end
                end
                PH_CRC_HI:
                begin
                    m_crc_high = b;
                    m_phase    = PH_CRC_LO;
                end
                PH_CRC_LO:
                begin
                    if ({m_crc_high, b} == m_crc)
                    begin
                        m_good = m_good + 32'd1;
                        queue_event(EV_OK, 8'h00, m_frame_len);
                    end
                    else
                    begin
                        m_crc_err = m_crc_err + 32'd1;
                        queue_event(EV_CRC, 8'h00, m_frame_len);
                    end
                    back_to_hunt();
                end
                default:
                begin
                    back_to_hunt();
                end
            endcase
        end
    endtask

    // one input transaction, with a random gap ahead of it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        decode_byte(b);
    endtask

    task automatic send_line(input logic [7:0] line[$], input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            send_byte(line[i]);
            frame_bytes++;
        end
    endtask

    // hold the sender until every predicted event has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write: setup cycle and access cycle, then the bus is left idle
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MAGIC:   cfg_magic   = value[7:0];
            REG_ESCAPE:  cfg_escape  = value[7:0];
            REG_XORMASK: cfg_mask    = value[7:0];
            REG_POLY:    cfg_poly    = value;
            REG_START:   cfg_start   = value;
            REG_MAXLEN:  cfg_max_len = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] magic, input logic [7:0] esc,
                              input logic [7:0] mask, input logic [15:0] poly,
                              input logic [15:0] start, input logic [15:0] max_len);
        drain_results();
        write_reg(REG_MAGIC, {8'h00, magic});
        write_reg(REG_ESCAPE, {8'h00, esc});
        write_reg(REG_XORMASK, {8'h00, mask});
        write_reg(REG_POLY, poly);
        write_reg(REG_START, start);
        write_reg(REG_MAXLEN, max_len);
        idle_on = ($urandom_range(0, 3) != 0);
    endtask

    // stuff a byte when it collides with magic or escape, unless escape equals magic
    task automatic push_stuffed(ref logic [7:0] line[$], input logic [7:0] b);
        if ((b == cfg_magic || b == cfg_escape) && cfg_escape != cfg_magic)
        begin
            line.push_back(cfg_escape);
            line.push_back(b ^ cfg_mask);
        end
        else
        begin
            line.push_back(b);
        end
    endtask

    // line image of a frame under the current registers
    task automatic build_frame(input logic [15:0] len_field, input logic [7:0] body[$],
                               input bit corrupt_crc, ref logic [7:0] line[$]);
        logic [15:0] crc;
        int          i;
        line.delete();
        line.push_back(cfg_magic);
        crc = crc16_update(cfg_start, cfg_magic, cfg_poly);
        push_stuffed(line, len_field[15:8]);
        crc = crc16_update(crc, len_field[15:8], cfg_poly);
        push_stuffed(line, len_field[7:0]);
        crc = crc16_update(crc, len_field[7:0], cfg_poly);
        for (i = 0; i < body.size(); i++)
        begin
            push_stuffed(line, body[i]);
            crc = crc16_update(crc, body[i], cfg_poly);
        end
        if (corrupt_crc)
        begin
            crc = crc ^ 16'($urandom_range(1, 65535));
        end
        push_stuffed(line, crc[15:8]);
        push_stuffed(line, crc[7:0]);
    endtask

    // mostly good frames; some damaged, cut, badly sized, or plain noise
    task automatic random_frame();
        logic [7:0]  body[$];
        logic [7:0]  line[$];
        logic [15:0] len_field;
        int          r;
        int          n;
        int          i;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
                send_byte(8'($urandom_range(0, 255)));
        end
        else if (r < 11)
        begin
            case ($urandom_range(0, 4))
                0:       len_field = 16'd0;
                1:       len_field = 16'd1;
                2:       len_field = cfg_max_len + 16'd1;
                3:       len_field = 16'hFFFF;
                default: len_field = 16'($urandom_range(0, 65535));
            endcase
            build_frame(len_field, body, 1'b0, line);
            send_line(line, line.size());
        end
        else
        begin
            n = pick_body_len();
            for (i = 0; i < n; i++)
                body.push_back(pick_body_byte());
            build_frame(16'(n), body, (r >= 11 && r < 19), line);
            if (r >= 19 && r < 27)
            begin
                send_line(line, $urandom_range(1, line.size() - 1));
            end
            else
            begin
                send_line(line, line.size());
            end
        end
    endtask

    task automatic run_traffic(input int n_bytes);
        int target;
        target = frame_bytes + n_bytes;
        while (frame_bytes < target)
        begin
            random_frame();
            if ($urandom_range(0, 24) == 0)
            begin
                drain_results();
            end
        end
    endtask

    // hunting noise, stuffed body, bad crc, cut frame, lengths out of range
    task automatic test_directed();
        logic [7:0] body[$];
        logic [7:0] line[$];
        send_byte(8'h00);
        send_byte(8'hFF);
        body.push_back(cfg_magic);
        body.push_back(cfg_escape);
        build_frame(16'd2, body, 1'b0, line);
        send_line(line, line.size());
        body.delete();
        body.push_back(8'h5A);
        body.push_back(8'hA5);
        build_frame(16'd2, body, 1'b1, line);
        send_line(line, line.size());
        body.delete();
        body.push_back(8'h11);
        body.push_back(8'h22);
        body.push_back(8'h33);
        build_frame(16'd3, body, 1'b0, line);
        send_line(line, 4);
        send_byte(cfg_magic);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(cfg_magic);
        send_byte(8'hFF);
        send_byte(8'hFF);
    endtask

    // reset registers, with a full pause of the sender midway
    task automatic test_default_traffic();
        idle_on = 1'b1;
        run_traffic(150);
        drain_results();
        idle_on = 1'b0;
        run_traffic(150);
    endtask

    task automatic test_config_extremes();
        set_config(8'h00, 8'hFF, 8'hFF, 16'h0000, 16'h0000, 16'd2);
        run_traffic(150);
        set_config(8'hFF, 8'h00, 8'h01, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_traffic(150);
        // every length rejected
        set_config(DEF_MAGIC, DEF_ESCAPE, DEF_XORMASK, DEF_POLY, DEF_START, 16'd0);
        run_traffic(60);
        set_config(DEF_MAGIC, DEF_ESCAPE, DEF_XORMASK, DEF_POLY, DEF_START, 16'd1);
        run_traffic(60);
        // escape equal to magic acts as magic
        set_config(8'h7E, 8'h7E, 8'h20, 16'h1021, 16'hFFFF, 16'd12);
        run_traffic(100);
        // zero mask: stuffed magic still restarts the frame
        set_config(8'h7E, 8'h7D, 8'h00, 16'h1021, 16'h0000, 16'd5);
        run_traffic(100);
    endtask

    task automatic test_random_config();
        logic [7:0]  magic;
        logic [15:0] max_len;
        int          r;
        while (frame_bytes < TOTAL_BYTES)
        begin
            magic = 8'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                max_len = 16'($urandom_range(2, 40));
            end
            else if (r < 85)
            begin
                max_len = 16'($urandom_range(0, 3));
            end
            else
            begin
                max_len = 16'($urandom_range(41, 65535));
            end
            set_config(magic,
                       ($urandom_range(0, 9) == 0) ? magic : 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), max_len);
            run_traffic(200);
        end
    endtask

    // result side: random backpressure
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else if (!idle_on || $urandom_range(0, 99) < 65)
        begin
            out_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 6);
        end
        else
        begin
            out_ready  <= 1'b0;
            ready_hold <= stall_length();
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin : result_check
        frame_event_t seen;
        frame_event_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen = {event_kind, data_byte, byte_index, good_frames, crc_error_frames,
                    truncated_frames, skipped_bytes};
            if (expected_events.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected event kind %0d data %02h index %0d",
                             $time, seen.kind, seen.data, seen.index);
                end
            end
            else
            begin
                want = expected_events.pop_front();
                if (seen !== want)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("%0t: expected kind %0d data %02h index %0d cnt %0d %0d %0d %0d",
                                 $time, want.kind, want.data, want.index, want.good,
                                 want.crc_err, want.trunc, want.skipped);
                        $display("%0t:   actual kind %0d data %02h index %0d cnt %0d %0d %0d %0d",
                                 $time, seen.kind, seen.data, seen.index, seen.good,
                                 seen.crc_err, seen.trunc, seen.skipped);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_escaped_frame_decoder_crc16_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        model_reset();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_default_traffic();
        test_config_extremes();
        test_random_config();
        drain_results();
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        error_count += expected_events.size();
        if (error_count == 0)
        begin
            $display("tb_escaped_frame_decoder_crc16_top OK");
        end
        else
        begin
            $display("tb_escaped_frame_decoder_crc16_top NOT OK");
        end
        $finish;
    end

endmodule
